// ===== sv/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared constants, command/status bundles and the result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned MAX_STORED_DEF = 16;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END = 8'hF7;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] CLASS_MASK   = 8'hE0;
  localparam logic [7:0] CLASS_ONE    = 8'hC0;

  localparam logic [23:0] TEMPO_RESET = 24'd500000;

  typedef struct packed {
    logic take;
    logic flush;
    logic load_hdr;
    logic load_byte;
    logic clear;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic n_zero;
    logic idx_last;
  } sts_t;

  typedef struct packed {
    logic        part;
    logic [31:0] delta_time;
    logic [7:0]  status;
    logic [7:0]  meta_type;
    logic [31:0] data_length;
    logic [23:0] tempo;
    logic [7:0]  payload_byte;
    logic        last;
  } evt_t;

  function automatic logic [31:0] chan_count(logic [7:0] st);
    return ((st & CLASS_MASK) == CLASS_ONE) ? 32'd1 : 32'd2;
  endfunction

endpackage

// ===== sv/mtep_in_if.sv =====
// ----------------------------------------------------------------------------
// Track byte channel
// Valid/ready channel carrying one track chunk byte per transfer.
// ----------------------------------------------------------------------------
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_last;

  modport source (output valid, output track_byte, output track_last, input ready);
  modport sink   (input valid, input track_byte, input track_last, output ready);
endinterface

// ===== sv/mtep_out_if.sv =====
// ----------------------------------------------------------------------------
// Event result channel
// Valid/ready channel carrying one header or stored data byte per transfer.
// ----------------------------------------------------------------------------
interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic        part;
  logic [31:0] delta_time;
  logic [7:0]  status;
  logic [7:0]  meta_type;
  logic [31:0] data_length;
  logic [23:0] tempo;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output part, output delta_time, output status,
                  output meta_type, output data_length, output tempo,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input part, input delta_time, input status,
                  input meta_type, input data_length, input tempo,
                  input payload_byte, input last, output ready);
endinterface

// ===== sv/mtep_datapath.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser datapath
// Parse registers, data byte store, tempo register and result register.
// ----------------------------------------------------------------------------
module mtep_datapath
  import mtep_pkg::*;
#(
  parameter int unsigned MAX_STORED = MAX_STORED_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [7:0] track_byte_i,
  output evt_t       evt_o
);

  localparam int unsigned CntW  = $clog2(MAX_STORED + 1);
  localparam int unsigned AddrW = $clog2(MAX_STORED);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_STORED);

  typedef enum logic [2:0] {
    PH_DSTART, PH_DCONT, PH_STATUS, PH_MTYPE, PH_MLEN, PH_DATA, PH_SYSEX
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [31:0]     delta_q, delta_d;
  logic [7:0]      cur_q, cur_d;
  logic [7:0]      run_q, run_d;
  logic [7:0]      meta_q, meta_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     rem_q, rem_d;
  logic [CntW-1:0] stored_q, stored_d;
  logic [CntW-1:0] real_q, real_d;
  logic [23:0]     tempo_q, tempo_d;
  logic [7:0]      tb_q [3];
  logic [7:0]      tb_d [3];
  logic [7:0]      tb_m [3];
  logic [AddrW-1:0] idx_q, idx_d;
  evt_t            evt_q, evt_d;

  logic [7:0]      mem [MAX_STORED];
  logic [7:0]      rd_q;

  logic [7:0]      byte_v;
  logic            step;
  logic            keep_en;
  logic            we;
  logic            done;
  logic [CntW-1:0] room;
  logic            is_meta;
  logic            is_sysex;
  logic [31:0]     dl;
  logic [7:0]      mt;
  logic [23:0]     tempo_new;
  logic            idx_last;

  always_comb begin
    byte_v   = cmd_i.flush ? 8'h00 : track_byte_i;
    step     = cmd_i.take || cmd_i.flush;
    room     = MaxCnt - stored_q;
    phase_d  = phase_q;
    delta_d  = delta_q;
    cur_d    = cur_q;
    run_d    = run_q;
    meta_d   = meta_q;
    len_d    = len_q;
    rem_d    = rem_q;
    stored_d = stored_q;
    real_d   = real_q;
    tempo_d  = tempo_q;
    idx_d    = idx_q;
    evt_d    = evt_q;
    keep_en  = 1'b0;
    done     = 1'b0;

    if (step) begin
      if (cmd_i.flush && phase_q == PH_SYSEX) begin
        keep_en = (stored_q == '0);
        done    = 1'b1;
      end else if (cmd_i.flush && phase_q == PH_DATA) begin
        // pad missing bytes with zeros; entries past real_q read as zero
        if (rem_q >= 32'(room)) begin
          stored_d = MaxCnt;
        end else begin
          stored_d = stored_q + rem_q[CntW-1:0];
        end
        rem_d = '0;
        done  = 1'b1;
      end else begin
        unique case (phase_q)
          PH_STATUS: begin
            if (byte_v == ST_META) begin
              cur_d   = byte_v;
              phase_d = PH_MTYPE;
            end else if (byte_v == ST_SYSEX || byte_v == ST_SYSEX_END) begin
              cur_d    = byte_v;
              stored_d = '0;
              real_d   = '0;
              phase_d  = PH_SYSEX;
            end else if (byte_v[7]) begin
              run_d    = byte_v;
              cur_d    = byte_v;
              len_d    = chan_count(byte_v);
              rem_d    = len_d;
              stored_d = '0;
              real_d   = '0;
              phase_d  = PH_DATA;
            end else begin
              cur_d   = run_q;
              len_d   = chan_count(run_q);
              keep_en = 1'b1;
              rem_d   = len_d - 32'd1;
              if (rem_d == '0) begin
                done = 1'b1;
              end else begin
                phase_d = PH_DATA;
              end
            end
          end
          PH_MTYPE: begin
            meta_d  = byte_v;
            len_d   = '0;
            phase_d = PH_MLEN;
          end
          PH_MLEN: begin
            len_d = {len_q[24:0], byte_v[6:0]};
            if (!byte_v[7]) begin
              rem_d    = len_d;
              stored_d = '0;
              real_d   = '0;
              if (len_d == '0) begin
                done = 1'b1;
              end else begin
                phase_d = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            keep_en = 1'b1;
            if (rem_q != '0) begin
              rem_d = rem_q - 32'd1;
            end
            done = (rem_d == '0);
          end
          PH_SYSEX: begin
            keep_en = 1'b1;
            done    = (byte_v == ST_SYSEX_END);
          end
          default: begin
            delta_d = {delta_q[24:0], byte_v[6:0]};
            phase_d = byte_v[7] ? PH_DCONT : PH_STATUS;
          end
        endcase
      end
    end

    we = keep_en && (stored_q < MaxCnt);
    if (we) begin
      stored_d = stored_q + CntW'(1);
      real_d   = stored_q + CntW'(1);
    end
    for (int k = 0; k < 3; k++) begin
      tb_d[k] = (we && stored_q == CntW'(k)) ? byte_v : tb_q[k];
      tb_m[k] = (real_q > CntW'(k)) ? tb_q[k] : 8'h00;
    end

    is_meta   = (cur_q == ST_META);
    is_sysex  = (cur_q == ST_SYSEX) || (cur_q == ST_SYSEX_END);
    dl        = is_sysex ? 32'(stored_q) : len_q;
    mt        = is_meta ? meta_q : 8'h00;
    tempo_new = (is_meta && meta_q == META_TEMPO) ? {tb_m[0], tb_m[1], tb_m[2]} : tempo_q;
    idx_last  = ((CntW'(idx_q) + CntW'(1)) == stored_q);

    if (cmd_i.load_hdr) begin
      tempo_d = tempo_new;
      evt_d   = '{part: 1'b0, delta_time: delta_q, status: cur_q, meta_type: mt,
                  data_length: dl, tempo: tempo_new, payload_byte: 8'h00,
                  last: (stored_q == '0)};
    end
    if (cmd_i.load_byte) begin
      evt_d = '{part: 1'b1, delta_time: delta_q, status: cur_q, meta_type: mt,
                data_length: dl, tempo: tempo_new,
                payload_byte: (CntW'(idx_q) < real_q) ? rd_q : 8'h00,
                last: idx_last};
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + AddrW'(1);
    end
    if (cmd_i.clear) begin
      phase_d  = PH_DSTART;
      delta_d  = '0;
      len_d    = '0;
      rem_d    = '0;
      stored_d = '0;
      real_d   = '0;
      idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DSTART;
      delta_q  <= '0;
      cur_q    <= '0;
      run_q    <= '0;
      meta_q   <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      stored_q <= '0;
      real_q   <= '0;
      tempo_q  <= TEMPO_RESET;
      idx_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      delta_q  <= delta_d;
      cur_q    <= cur_d;
      run_q    <= run_d;
      meta_q   <= meta_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      stored_q <= stored_d;
      real_q   <= real_d;
      tempo_q  <= tempo_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
    for (int k = 0; k < 3; k++) begin
      tb_q[k] <= tb_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[stored_q[AddrW-1:0]] <= byte_v;
    end
    rd_q <= mem[idx_q];
  end

  assign sts_o = '{done: done, n_zero: (stored_q == '0), idx_last: idx_last};
  assign evt_o = evt_q;

  a_stored_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= MaxCnt)
    else $error("stored count exceeds store depth");

  a_real_le_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    real_q <= stored_q)
    else $error("written count exceeds stored count");

endmodule

// ===== sv/mtep_ctrl.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser controller
// Sequences byte intake, end-of-track completion and result emission.
// ----------------------------------------------------------------------------
module mtep_ctrl
  import mtep_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [2:0] {S_IN, S_FLUSH, S_HDR, S_RD, S_BYTE} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   free;

  always_comb begin
    free        = !out_valid_q || out_ready_i;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IN: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.done) begin
            state_d = S_HDR;
          end else if (in_last_i) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (sts_i.done) begin
          state_d = S_HDR;
        end
      end
      S_HDR: begin
        if (free) begin
          cmd_o.load_hdr = 1'b1;
          out_valid_d    = 1'b1;
          if (sts_i.n_zero) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IN;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_BYTE;
      end
      S_BYTE: begin
        if (free) begin
          cmd_o.load_byte = 1'b1;
          out_valid_d     = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IN;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IN);
  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_hdr || cmd_o.load_byte) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && $past(state_q) == S_FLUSH && $past(state_q, 2) == S_FLUSH)
    |-> sts_i.done)
    else $error("completion did not finish in three steps");

  a_clear_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> in_ready_o)
    else $error("intake not resumed after event emission");

endmodule

// ===== sv/midi_track_event_parser_core.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Parses track chunk bytes into event headers and stored data bytes.
// ----------------------------------------------------------------------------
// Usage:
//   track_i takes one track byte per transfer; track_last marks the final
//   byte of the chunk. event_o gives, for each finished event, a header
//   (part 0) and then each stored data byte (part 1), last set on the final.
//   A byte that does not finish an event is taken at once, so bytes
//   stream at one per cycle. A finishing byte stops intake until the last
//   result of its event is loaded into the output register: the header is
//   loaded in the header state once the output register is free, and each
//   stored byte passes a store read state and then a load, also held while
//   the output register is not free. On a last byte that leaves an event
//   open, completion steps that feed zero bytes run first.
//   A stalled receiver holds the output register; the parser waits.
//   Reset returns to awaiting a delta time with tempo 500000 and no
//   running status; no clearing pass runs.
// ----------------------------------------------------------------------------
module midi_track_event_parser_core
  import mtep_pkg::*;
#(
  parameter int unsigned MAX_STORED = MAX_STORED_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  mtep_in_if.sink    track_i,
  mtep_out_if.source event_o
);

  cmd_t cmd;
  sts_t sts;
  evt_t evt;
  logic out_valid;
  logic in_ready;

  mtep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (track_i.valid),
    .in_last_i   (track_i.track_last),
    .in_ready_o  (in_ready),
    .out_ready_i (event_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mtep_datapath #(
    .MAX_STORED (MAX_STORED)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .track_byte_i (track_i.track_byte),
    .evt_o        (evt)
  );

  assign track_i.ready        = in_ready;
  assign event_o.valid        = out_valid;
  assign event_o.part         = evt.part;
  assign event_o.delta_time   = evt.delta_time;
  assign event_o.status       = evt.status;
  assign event_o.meta_type    = evt.meta_type;
  assign event_o.data_length  = evt.data_length;
  assign event_o.tempo        = evt.tempo;
  assign event_o.payload_byte = evt.payload_byte;
  assign event_o.last         = evt.last;

endmodule
